// ----- rtl/fra_pkg.sv -----
// Shared constants and types for the frequency-to-text readout.
// No dependencies.
`default_nettype none
package fra_pkg;
    localparam int TEXT_LEN_DEF = 16;
    localparam int CLK_W = 27;
    localparam int HALF_W = 16;
    localparam int CNT_W = 32;
    localparam int PROD_W = 59;
    localparam int CHAR_W = 8;
    localparam int IDX_W = 5;
    localparam int QDEPTH = 2;
    localparam logic [CLK_W-1:0] REF_CLOCK_RESET = 27'd24000000;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_H = 8'h48;
    localparam logic [CHAR_W-1:0] CH_K = 8'h4B;
    localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
    localparam int POINT_POS = 6;
    localparam int DIGITS_START = 3;

    typedef struct packed {
        logic [CNT_W-1:0] sig;
        logic [CNT_W-1:0] refc;
        logic [CLK_W-1:0] clk_hz;
    } job_t;
endpackage
`default_nettype wire

// ----- rtl/fra_front.sv -----
// Front end: forms the counts and queues jobs for the back end.
// Depends on fra_pkg.
`default_nettype none
module fra_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [fra_pkg::HALF_W-1:0]     sig_count_low,
    input  wire logic [fra_pkg::HALF_W-1:0]     sig_count_high,
    input  wire logic [fra_pkg::HALF_W-1:0]     ref_count_low,
    input  wire logic [fra_pkg::HALF_W-1:0]     ref_count_high,
    input  wire logic [fra_pkg::CLK_W-1:0]      clk_hz,
    output logic                                full,
    output logic                                empty,
    output fra_pkg::job_t                       job,
    input  wire logic                           pop
);
    fra_pkg::job_t q_reg [fra_pkg::QDEPTH];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    assign full  = (cnt_reg == 2'(fra_pkg::QDEPTH));
    assign empty = (cnt_reg == 2'd0);
    assign push  = start && !full;
    assign job   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].sig    <= {sig_count_high, sig_count_low} + 32'd1;
            q_reg[wp_reg].refc   <= {ref_count_high, ref_count_low} + 32'd1;
            q_reg[wp_reg].clk_hz <= clk_hz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/fra_back.sv -----
// Back end: multiply, restoring divide, digit extraction and byte emission.
// Depends on fra_pkg.
`default_nettype none
module fra_back #(
    parameter int TEXT_LEN = fra_pkg::TEXT_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           empty,
    input  fra_pkg::job_t                       job,
    output logic                                pop,
    output logic                                valid,
    output logic [fra_pkg::CHAR_W-1:0]          text_char,
    output logic [fra_pkg::IDX_W-1:0]           char_index,
    output logic                                last_char
);
    localparam int PW = fra_pkg::PROD_W;
    localparam int DW = 10;   // milli divide quotient bits
    localparam int LW = $clog2(TEXT_LEN);
    localparam logic [1:0] U_HZ  = 2'd0;
    localparam logic [1:0] U_KHZ = 2'd1;
    localparam logic [1:0] U_MHZ = 2'd2;
    localparam logic [1:0] U_DIV = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_DIV = 7'b0000100,
        S_MIL  = 7'b0001000, S_SEL = 7'b0010000, S_DIG = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [PW-1:0] quo_reg, quo_next;          // dividend shifts out, quotient in
    logic [fra_pkg::CNT_W:0] rem_reg, rem_next;
    logic [fra_pkg::CNT_W-1:0] den_reg, den_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [DW-1:0] mil_reg, mil_next;
    logic [1:0] unit_reg, unit_next;
    logic [fra_pkg::CNT_W-1:0] val_reg, val_next;
    logic [fra_pkg::IDX_W-1:0] pos_reg, pos_next;
    logic [fra_pkg::CHAR_W-1:0] line_reg [TEXT_LEN];
    logic [fra_pkg::CHAR_W-1:0] line_next [TEXT_LEN];
    logic [fra_pkg::CNT_W:0] trial;
    logic [fra_pkg::CNT_W:0] sh;
    logic [fra_pkg::CNT_W-1:0] q10;
    logic [3:0] r10;
    logic [63:0] p10;
    logic [41:0] mil_dd;
    logic [PW-1:0] whole;

    assign pop = (state_reg == S_IDLE) && !empty;
    assign whole = quo_reg;
    assign mil_dd = 42'(rem_reg[fra_pkg::CNT_W-1:0]) * 42'd1000;

    always_comb
    begin
        p10 = {32'd0, val_reg} * 64'hCCCCCCCD;
        q10 = 32'(p10[63:35]);
        r10 = 4'(val_reg - q10 * 32'd10);
    end

    always_comb
    begin
        state_next = state_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        mil_next = mil_reg;
        unit_next = unit_reg;
        val_next = val_reg;
        pos_next = pos_reg;
        line_next = line_reg;
        sh = '0;
        trial = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    den_next = job.refc;
                    quo_next = PW'(job.sig) * PW'(job.clk_hz);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                rem_next = '0;
                cnt_next = 6'(PW);
                if (den_reg == '0)
                begin
                    quo_next = '0;
                    mil_next = '0;
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                sh = {rem_reg[fra_pkg::CNT_W-1:0], quo_reg[PW-1]};
                trial = sh - {1'b0, den_reg};
                if (!trial[fra_pkg::CNT_W])
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh;
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    cnt_next = 6'(DW);
                    mil_next = '0;
                    state_next = S_MIL;
                end
            end
            S_MIL:
            begin
                // long division of rem*1000 by den, bit by bit from the left
                if (cnt_reg == 6'(DW))
                begin
                    sh = 33'(mil_dd >> (DW - 1));
                    val_next = {val_reg[fra_pkg::CNT_W-1-DW:0], mil_dd[DW-1:0]};
                end
                else
                begin
                    sh = {rem_reg[fra_pkg::CNT_W-1:0], val_reg[DW-1]};
                end
                trial = sh - {1'b0, den_reg};
                val_next = {val_next[fra_pkg::CNT_W-2:0], 1'b0};
                if (!trial[fra_pkg::CNT_W])
                begin
                    rem_next = trial;
                    mil_next = {mil_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh;
                    mil_next = {mil_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                for (int i = 0; i < TEXT_LEN; i++)
                begin
                    line_next[i] = fra_pkg::CH_SPACE;
                end
                line_next[0] = fra_pkg::CH_Z;
                line_next[1] = fra_pkg::CH_H;
                val_next = (whole[PW-1:fra_pkg::CNT_W] != '0) ? '1
                         : whole[fra_pkg::CNT_W-1:0];
                if (whole < PW'(1000))
                begin
                    unit_next = U_HZ;
                    line_next[2] = fra_pkg::CH_SPACE;
                    line_next[fra_pkg::POINT_POS] = fra_pkg::CH_POINT;
                    val_next = 32'(mil_reg);
                    pos_next = 5'(fra_pkg::DIGITS_START);
                    cnt_next = 6'd3;
                end
                else if (whole < PW'(1000000))
                begin
                    unit_next = U_KHZ;
                    line_next[2] = fra_pkg::CH_K;
                    pos_next = 5'(fra_pkg::DIGITS_START);
                    cnt_next = 6'd0;
                end
                else
                begin
                    unit_next = U_MHZ;
                    line_next[2] = fra_pkg::CH_M;
                    pos_next = 5'(fra_pkg::DIGITS_START);
                    cnt_next = 6'd0;
                end
                state_next = S_DIG;
            end
            S_DIG:
            begin
                if (unit_reg == U_MHZ)
                begin
                    // divide by 1000 as three divides by 10
                    val_next = q10;
                    unit_next = U_DIV;
                    cnt_next = 6'd2;
                end
                else if (unit_reg == U_DIV)
                begin
                    val_next = q10;
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        unit_next = U_KHZ;
                    end
                end
                else if (cnt_reg != 6'd0)
                begin
                    // milli digits, fixed three
                    line_next[pos_reg[LW-1:0]] = fra_pkg::CH_ZERO + 8'(r10);
                    val_next = q10;
                    pos_next = pos_reg + 5'd1;
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        val_next = (whole[PW-1:fra_pkg::CNT_W] != '0) ? '1
                                 : whole[fra_pkg::CNT_W-1:0];
                        pos_next = 5'(fra_pkg::POINT_POS + 1);
                    end
                end
                else if (val_reg == '0 || 32'(pos_reg) >= 32'(TEXT_LEN))
                begin
                    pos_next = '0;
                    state_next = S_OUT;
                end
                else if (unit_reg == U_KHZ && pos_reg == 5'(fra_pkg::POINT_POS))
                begin
                    line_next[pos_reg[LW-1:0]] = fra_pkg::CH_POINT;
                    pos_next = pos_reg + 5'd1;
                end
                else
                begin
                    line_next[pos_reg[LW-1:0]] = fra_pkg::CH_ZERO + 8'(r10);
                    val_next = q10;
                    pos_next = pos_reg + 5'd1;
                end
            end
            S_OUT:
            begin
                pos_next = pos_reg + 5'd1;
                if (pos_reg == 5'(TEXT_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign valid = (state_reg == S_OUT);
    assign text_char = line_reg[pos_reg[LW-1:0]];
    assign char_index = pos_reg;
    assign last_char = (pos_reg == 5'(TEXT_LEN - 1));

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        mil_reg <= mil_next;
        val_reg <= val_next;
        line_reg <= line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            unit_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            unit_reg <= unit_next;
            pos_reg <= pos_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/frequency_ratio_to_ascii.sv -----
// Top level of the frequency-to-text readout.
// Depends on fra_pkg, fra_front and fra_back.
// An item is taken from the queue, multiplied, put through 59 one-bit divide
// steps and 10 steps for the fraction, and its unit is selected; then its
// digits are written one per cycle, and the TEXT_LEN bytes go out with
// strobe high, one byte per cycle. A zero reference count skips the 69
// divide steps. Two items queue while one runs; busy is high while the queue
// is full. The receiver cannot stall output.
`default_nettype none
module frequency_ratio_to_ascii #(
    parameter int TEXT_LEN = fra_pkg::TEXT_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [fra_pkg::HALF_W-1:0]     sig_count_low,
    input  wire logic [fra_pkg::HALF_W-1:0]     sig_count_high,
    input  wire logic [fra_pkg::HALF_W-1:0]     ref_count_low,
    input  wire logic [fra_pkg::HALF_W-1:0]     ref_count_high,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fra_pkg::CLK_W-1:0]      cfg_data,
    output logic                                strobe,
    output logic [fra_pkg::CHAR_W-1:0]          text_char,
    output logic [fra_pkg::IDX_W-1:0]           char_index,
    output logic                                last_char
);
    logic [fra_pkg::CLK_W-1:0] clk_hz_reg;
    logic empty, pop;
    fra_pkg::job_t job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= fra_pkg::REF_CLOCK_RESET;
        end
        else if (cfg_valid)
        begin
            clk_hz_reg <= cfg_data;
        end
    end

    fra_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start),
        .sig_count_low(sig_count_low), .sig_count_high(sig_count_high),
        .ref_count_low(ref_count_low), .ref_count_high(ref_count_high),
        .clk_hz(clk_hz_reg), .full(busy), .empty(empty), .job(job), .pop(pop)
    );

    fra_back #(.TEXT_LEN(TEXT_LEN)) u_back (
        .clk(clk), .rst_n(rst_n), .empty(empty), .job(job), .pop(pop),
        .valid(strobe), .text_char(text_char), .char_index(char_index),
        .last_char(last_char)
    );
endmodule
`default_nettype wire
